### src/fpsc_pkg.sv
package fpsc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int PLANE_COUNT = 6;
	localparam int FIX_W       = 32;
	// numerator of the normalizing divide: |raw| scaled by 2^FRAC_BITS
	localparam int NUM_W       = FIX_W + FRAC_BITS;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	typedef logic [3:0][FIX_W-1:0] vec4_t;

	// column paired with column 3 for each plane
	function automatic logic [1:0] plane_col(input logic [2:0] p);
		logic [1:0] c;
		case (p)
			3'd0, 3'd1: c = 2'd0;
			3'd2, 3'd3: c = 2'd1;
			default:    c = 2'd2;
		endcase
		return c;
	endfunction

	// 1 where the plane subtracts its column from column 3
	function automatic logic plane_sub(input logic [2:0] p);
		logic s;
		case (p)
			3'd1, 3'd2, 3'd5: s = 1'b1;
			default:          s = 1'b0;
		endcase
		return s;
	endfunction

endpackage

### src/fpsc_norm.sv
module fpsc_norm import fpsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  vec4_t raw,
	output logic  done,
	output vec4_t plane
);

	localparam int DCNT_W = $clog2(NUM_W);
	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_SQ   = 3'd1;
	localparam logic [2:0] N_SQRT = 3'd2;
	localparam logic [2:0] N_DIV  = 3'd3;
	localparam logic [2:0] N_FIN  = 3'd4;

	logic [2:0]        st_q;
	logic [1:0]        i_q;
	logic [1:0]        c_q;
	logic [DCNT_W-1:0] n_q;
	logic              done_q;
	vec4_t             raw_q;
	vec4_t             plane_q;
	logic [63:0]       prod_q;
	logic [63:0]       acc_q;
	logic [63:0]       res_q;
	logic [63:0]       bit_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [FIX_W-1:0]  rem_q;

	logic [63:0]       trial;
	logic [FIX_W-1:0]  len;
	logic [FIX_W:0]    r2;
	logic              ge;
	logic [1:0]        c_nxt;
	logic [FIX_W-1:0]  mag_nxt;
	logic [FIX_W-1:0]  mag0;
	logic [30:0]       q31;
	logic [FIX_W-1:0]  qval;
	logic signed [63:0] sq;

	assign trial   = res_q + bit_q;
	assign len     = res_q[FIX_W-1:0];
	assign r2      = {rem_q, num_q[NUM_W-1]};
	assign ge      = r2 >= {1'b0, len};
	assign c_nxt   = c_q + 2'd1;
	assign mag0    = raw_q[0][FIX_W-1] ? -raw_q[0] : raw_q[0];
	assign mag_nxt = raw_q[c_nxt][FIX_W-1] ? -raw_q[c_nxt] : raw_q[c_nxt];
	assign q31     = (|quo_q[NUM_W-1:31]) ? '1 : quo_q[30:0];
	assign qval    = raw_q[c_q][FIX_W-1] ? -{1'b0, q31} : {1'b0, q31};
	assign sq      = $signed(raw_q[i_q]) * $signed(raw_q[i_q]);

	assign done  = done_q;
	assign plane = plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				N_IDLE: if (start) st_q <= N_SQ;
				N_SQ: if (i_q == 2'd3) st_q <= N_SQRT;
				N_SQRT: begin
					if (bit_q == '0) begin
						if (res_q == '0) begin
							done_q <= 1'b1;
							st_q   <= N_IDLE;
						end else begin
							st_q <= N_DIV;
						end
					end
				end
				N_DIV: if (n_q == '0) st_q <= N_FIN;
				N_FIN: begin
					if (c_q == 2'd3) begin
						done_q <= 1'b1;
						st_q   <= N_IDLE;
					end else begin
						st_q <= N_DIV;
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				raw_q <= raw;
				i_q   <= '0;
				acc_q <= '0;
			end
			N_SQ: begin
				// one square a cycle, accumulate the one before
				if (i_q != 2'd3) prod_q <= sq;
				if (i_q != 2'd0) acc_q <= acc_q + prod_q;
				i_q   <= i_q + 2'd1;
				bit_q <= 64'd1 << 62;
				res_q <= '0;
			end
			N_SQRT: begin
				if (bit_q != '0) begin
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					if (res_q == '0) plane_q <= '0;
					c_q   <= '0;
					num_q <= {mag0, {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					n_q   <= DCNT_W'(NUM_W - 1);
				end
			end
			N_DIV: begin
				// restoring divide, one quotient bit a cycle
				rem_q <= ge ? FIX_W'(r2 - {1'b0, len}) : r2[FIX_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				num_q <= num_q << 1;
				n_q   <= n_q - 1'b1;
			end
			N_FIN: begin
				plane_q[c_q] <= qval;
				c_q   <= c_nxt;
				num_q <= {mag_nxt, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				n_q   <= DCNT_W'(NUM_W - 1);
			end
			default: ;
		endcase
	end

endmodule

### src/frustum_plane_sphere_cull.sv
// Frustum plane builder and sphere culler, signed fixed point with FRAC_BITS
// fraction bits. One input channel (in_valid / in_stall) carries a word with
// an op: load one matrix entry, rebuild the six planes from the matrix, or
// test a sphere. Only a sphere test produces an output word (out_valid /
// out_stall) holding visible.
// in_stall is high while an op is in progress; one op is worked at a time.
// Load: taken without stalling. Rebuild: paced by the shared normalizer,
// which squares one component a cycle, takes a 32-step square root and then
// four restoring divides of NUM_W steps each, one bit a cycle, per plane.
// Sphere test: the result reaches the output register before the next test
// word is accepted; the plane memory delivers one plane (one 128-bit row) a
// cycle into a three-stage dot product pipeline, and six planes are read.
// The output register decouples the receiver: a new word is accepted while a
// result still waits; only when a second result is ready and the register is
// still stalled does the block hold in its final state.
// Reset clears the matrix and plane valid flags, so both stores read as zero
// until written; a sphere test before any rebuild sees six all-zero planes.
module frustum_plane_sphere_cull import fpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  entry_index,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] sphere_x,
	input  logic signed [31:0] sphere_y,
	input  logic signed [31:0] sphere_z,
	input  logic signed [31:0] sphere_radius,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        visible
);

	localparam int D_W = 2 * FIX_W + 2;   // exact four-term dot product
	localparam int L_W = FIX_W + FRAC_BITS + 1;
	localparam logic [2:0] LAST_P = 3'(PLANE_COUNT - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RA    = 3'd1;
	localparam logic [2:0] S_RB    = 3'd2;
	localparam logic [2:0] S_NWAIT = 3'd3;
	localparam logic [2:0] S_TEST  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_PUT   = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  p_q;
	logic [1:0]  k_q;
	logic [15:0] mat_vld_q;
	logic        pl_vld_q;
	logic        cull_q;
	logic        start_q;
	logic        out_valid_q;
	logic        visible_q;
	logic        tv_s1, tv_s2, tv_s3;
	logic        last_s1, last_s2, last_s3;

	vec4_t       mat_mem [4];
	vec4_t       plane_mem [PLANE_COUNT];
	vec4_t       mat_rd_q;
	logic [3:0]  mvld_q;
	vec4_t       pl_rd_q;
	vec4_t       raw_q;

	logic signed [FIX_W-1:0] sx_q, sy_q, sz_q;
	logic signed [L_W-1:0]   limit_q;
	logic signed [63:0]      px_s2, py_s2, pz_s2;
	logic signed [FIX_W-1:0] w_s2;
	logic signed [D_W-1:0]   sa_s3, sb_s3;

	logic        acc;
	logic        mat_we;
	logic        pl_we;
	logic        out_load;
	logic        nrm_done;
	vec4_t       nrm_plane;
	vec4_t       elem;
	vec4_t       pl_eff;
	logic [1:0]  col;
	logic signed [FIX_W:0]   sum33;
	logic signed [FIX_W-1:0] sat;
	logic signed [D_W-1:0]   d;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign mat_we   = acc && (op == OP_LOAD);
	assign pl_we    = (state_q == S_NWAIT) && nrm_done;
	assign out_load = (state_q == S_PUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	// matrix row k holds m[k][0..3]; lanes never written read as zero
	always_comb begin
		for (int e = 0; e < 4; e++) begin
			elem[e] = mvld_q[e] ? mat_rd_q[e] : '0;
		end
		col   = plane_col(p_q);
		sum33 = plane_sub(p_q)
			? $signed({elem[3][FIX_W-1], elem[3]}) - $signed({elem[col][FIX_W-1], elem[col]})
			: $signed({elem[3][FIX_W-1], elem[3]}) + $signed({elem[col][FIX_W-1], elem[col]});
		if (sum33[FIX_W] != sum33[FIX_W-1]) begin
			sat = sum33[FIX_W] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
		end else begin
			sat = sum33[FIX_W-1:0];
		end
		pl_eff = pl_vld_q ? pl_rd_q : '0;
		d = sa_s3 + sb_s3;
	end

	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[entry_index[3:2]][entry_index[1:0]] <= entry_value;
		mat_rd_q <= mat_mem[k_q];
		mvld_q   <= mat_vld_q[{k_q, 2'b00} +: 4];
		if (pl_we) plane_mem[p_q] <= nrm_plane;
		pl_rd_q  <= plane_mem[p_q];
	end

	fpsc_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.raw    (raw_q),
		.done   (nrm_done),
		.plane  (nrm_plane)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p_q         <= '0;
			k_q         <= '0;
			mat_vld_q   <= '0;
			pl_vld_q    <= 1'b0;
			cull_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			tv_s1       <= 1'b0;
			tv_s2       <= 1'b0;
			tv_s3       <= 1'b0;
		end else begin
			start_q <= 1'b0;
			tv_s1   <= 1'b0;
			tv_s2   <= tv_s1;
			tv_s3   <= tv_s2;
			if (mat_we) mat_vld_q[entry_index] <= 1'b1;
			if (tv_s3 && (d <= D_W'(limit_q))) cull_q <= 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc && op == OP_BUILD) begin
						p_q     <= '0;
						k_q     <= '0;
						state_q <= S_RA;
					end else if (acc && op == OP_TEST) begin
						p_q     <= '0;
						cull_q  <= 1'b0;
						state_q <= S_TEST;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					if (k_q == 2'd3) begin
						start_q <= 1'b1;
						state_q <= S_NWAIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_RA;
					end
				end
				S_NWAIT: begin
					if (nrm_done) begin
						k_q <= '0;
						if (p_q == LAST_P) begin
							pl_vld_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							p_q     <= p_q + 3'd1;
							state_q <= S_RA;
						end
					end
				end
				S_TEST: begin
					// advance one plane read a cycle
					tv_s1 <= 1'b1;
					if (p_q == LAST_P) begin
						state_q <= S_DRAIN;
					end else begin
						p_q <= p_q + 3'd1;
					end
				end
				S_DRAIN: if (tv_s3 && last_s3) state_q <= S_PUT;
				S_PUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			sx_q    <= sphere_x;
			sy_q    <= sphere_y;
			sz_q    <= sphere_z;
			limit_q <= -$signed({sphere_radius[FIX_W-1], sphere_radius, {FRAC_BITS{1'b0}}});
		end
		if (state_q == S_RB) raw_q[k_q] <= sat;
		last_s1 <= (state_q == S_TEST) && (p_q == LAST_P);
		px_s2   <= $signed(pl_eff[0]) * sx_q;
		py_s2   <= $signed(pl_eff[1]) * sy_q;
		pz_s2   <= $signed(pl_eff[2]) * sz_q;
		w_s2    <= $signed(pl_eff[3]);
		last_s2 <= last_s1;
		sa_s3   <= D_W'(px_s2) + D_W'(py_s2);
		sb_s3   <= D_W'(pz_s2) + D_W'($signed({w_s2, {FRAC_BITS{1'b0}}}));
		last_s3 <= last_s2;
		if (out_load) visible_q <= !cull_q;
	end

	a_norm_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_done |-> (state_q == S_NWAIT))
		else $error("normalizer finished outside a rebuild");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(tv_s3 && last_s3) |-> (state_q == S_DRAIN))
		else $error("last plane result outside drain");

	a_planes_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pl_vld_q) |-> ($past(p_q) == LAST_P))
		else $error("plane store marked valid before the last plane");

	a_put_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_PUT) |-> $past(tv_s3 && last_s3))
		else $error("result placed before all planes were tested");

endmodule

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fpsc_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [3:0] entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] sphere_x;
	logic signed [31:0] sphere_y;
	logic signed [31:0] sphere_z;
	logic signed [31:0] sphere_radius;
	logic out_valid;
	logic out_stall;
	logic visible;

	// shadow copy of the block's state
	logic signed [31:0] mat_shadow [16];
	logic signed [31:0] plane_shadow [24];
	// expected visible flags, oldest first
	bit vis_queue [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int word_count;
	int result_count;
	int culled_count;

	frustum_plane_sphere_cull dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .entry_index(entry_index), .entry_value(entry_value),
		.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
		.sphere_radius(sphere_radius),
		.out_valid(out_valid), .out_stall(out_stall), .visible(visible)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hold the run to a fixed time budget and report a failure if it runs out
	initial begin
		#400ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned s);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// divide one raw component by the normal length, keeping its sign
	function automatic logic signed [31:0] scale_comp(longint raw, longint unsigned len);
		longint unsigned mag;
		longint unsigned quo;
		mag = raw < 0 ? -raw : raw;
		quo = (mag << FRAC_BITS) / len;
		if (quo > 64'd2147483647)
			quo = 64'd2147483647;
		return raw < 0 ? -$signed(quo[31:0]) : $signed(quo[31:0]);
	endfunction

	task automatic rebuild_shadow_planes();
		longint raw [4];
		longint a;
		longint b;
		longint unsigned sumsq;
		longint unsigned len;
		int col;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			col = (p < 2) ? 0 : (p < 4) ? 1 : 2;
			for (int k = 0; k < 4; k++) begin
				a = mat_shadow[k*4+3];
				b = mat_shadow[k*4+col];
				raw[k] = clamp32((p == 1 || p == 2 || p == 5) ? a - b : a + b);
			end
			sumsq = 0;
			for (int k = 0; k < 3; k++)
				sumsq += raw[k] * raw[k];
			len = int_sqrt(sumsq);
			for (int k = 0; k < 4; k++)
				plane_shadow[p*4+k] = (len == 0) ? 32'sd0 : scale_comp(raw[k], len);
		end
	endtask

	function automatic bit sphere_in_view(longint sx, longint sy, longint sz, longint r);
		longint one;
		longint limit;
		longint dot_sum;
		one = longint'(1) << FRAC_BITS;
		limit = -(r * one);
		for (int p = 0; p < PLANE_COUNT; p++) begin
			dot_sum = longint'(plane_shadow[p*4]) * sx + longint'(plane_shadow[p*4+1]) * sy
				+ longint'(plane_shadow[p*4+2]) * sz + longint'(plane_shadow[p*4+3]) * one;
			if (dot_sum <= limit)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// present one word, hold it until accepted, then update the shadow
	task automatic send_word(logic [1:0] code, logic [3:0] idx, logic [31:0] val,
		logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] rad);
		bit vis;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		entry_index <= idx;
		entry_value <= val;
		sphere_x <= sx;
		sphere_y <= sy;
		sphere_z <= sz;
		sphere_radius <= rad;
		do
			@(posedge clk);
		while (in_stall);
		word_count++;
		case (code)
			OP_LOAD: mat_shadow[idx] = val;
			OP_BUILD: rebuild_shadow_planes();
			OP_TEST: begin
				vis = sphere_in_view($signed(sx), $signed(sy), $signed(sz), $signed(rad));
				vis_queue.push_back(vis);
			end
			default: ;
		endcase
	endtask

	task automatic load_matrix(logic [31:0] vals [16]);
		for (int i = 0; i < 16; i++)
			send_word(OP_LOAD, i[3:0], vals[i], $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_sphere(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [31:0] rad);
		send_word(OP_TEST, 4'($urandom), $urandom, sx, sy, sz, rad);
	endtask

	// small fixed-point value, a few units either way
	function automatic logic [31:0] near_unit();
		return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
			: -$signed($urandom_range(0, 32'h0004_0000));
	endfunction

	function automatic logic [31:0] any_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return near_unit();
			default: return $urandom;
		endcase
	endfunction

	// drop valid and wait until every expected result has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (vis_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// zero planes, extreme entries, spare op and the edges of each field
	task automatic test_directed();
		logic [31:0] m [16];
		test_sphere(32'h0, 32'h0, 32'h0, 32'h0);
		test_sphere(32'h0, 32'h0, 32'h0, 32'h0000_0001);
		test_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(OP_SPARE, 4'hF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
		// identity matrix: a unit cube frustum
		foreach (m[i])
			m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
		load_matrix(m);
		send_word(OP_BUILD, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		test_sphere(32'h0, 32'h0, 32'h0, 32'h0000_8000);
		test_sphere(32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000);
		test_sphere(32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000);
		test_sphere(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
		// saturating entries drive some raw sums to the upper range limit
		foreach (m[i])
			m[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
		load_matrix(m);
		send_word(OP_BUILD, 4'h5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		test_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
		wait_drain();
	endtask

	// random mix: a fresh matrix with a rebuild, stray loads, spare ops and spheres
	task automatic test_random_frames(int words);
		logic [31:0] m [16];
		int stop_at;
		stop_at = word_count + words;
		while (word_count < stop_at) begin
			case ($urandom_range(0, 9))
				0: begin
					foreach (m[i])
						m[i] = any_value();
					load_matrix(m);
					send_word(OP_BUILD, 4'($urandom), $urandom, $urandom, $urandom,
						$urandom, $urandom);
				end
				1: send_word(OP_LOAD, 4'($urandom), any_value(), $urandom, $urandom,
					$urandom, $urandom);
				2: send_word(OP_SPARE, 4'($urandom), $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: test_sphere(any_value(), any_value(), any_value(), any_value());
			endcase
		end
		wait_drain();
	endtask

	// stall the result side at the requested rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (vis_queue.size() == 0) begin
				$display("%0t: unexpected result, visible %0b", $time, visible);
				fail_count++;
			end else begin
				if (vis_queue[0] == 1'b0)
					culled_count++;
				if (visible !== vis_queue[0]) begin
					$display("%0t: visible mismatch, expected %0b actual %0b",
						$time, vis_queue[0], visible);
					fail_count++;
				end
				void'(vis_queue.pop_front());
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOAD;
		entry_index = '0;
		entry_value = '0;
		sphere_x = '0;
		sphere_y = '0;
		sphere_z = '0;
		sphere_radius = '0;
		fail_count = 0;
		word_count = 0;
		result_count = 0;
		culled_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (mat_shadow[i])
			mat_shadow[i] = '0;
		foreach (plane_shadow[i])
			plane_shadow[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 21;
		recv_idle_pct = 85;
		test_random_frames(380);
		send_idle_pct = 85;
		recv_idle_pct = 21;
		test_random_frames(380);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(380);
		$display("Covered %0d input words, %0d sphere results (%0d culled).",
			word_count, result_count, culled_count);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
